### design/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared types and constants of the heightmap vertex normal engine.
// ----------------------------------------------------------------------------
`default_nettype none
package hvn_pkg;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_COLS  = 2'd1;
  localparam logic [1:0] CFG_SCALE = 2'd2;

  // accumulated vector width: |x|,|z| <= 6*255*255, y <= 6*255
  localparam int ACC_W = 20;
  localparam int SQ_W  = 40;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
  } vec_t;
endpackage
`default_nettype wire

### design/hvn_ram.sv
// ----------------------------------------------------------------------------
// hvn_ram
// Generic single-port-write / one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module hvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/hvn_norm.sv
// ----------------------------------------------------------------------------
// hvn_norm
// Normalizer: one component per pass, binary search of up to 16 steps for the
// largest n with (2n-1)^2*S <= a^2*2^32, multiplies split over cycles.
// ----------------------------------------------------------------------------
`default_nettype none
module hvn_norm
  import hvn_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire vec_t        vec,
  output logic             done,
  output logic [15:0]      nx,
  output logic [15:0]      ny,
  output logic [15:0]      nz
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_KK   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_MUL2 = 3'd7;

  logic [2:0]  state_r;
  vec_t        vec_r;
  logic [1:0]  comp_r;
  logic [1:0]  sqi_r;
  logic [SQ_W-1:0] sq_r, ax2_r, sqp_r;
  logic [15:0] lo_r, hi_r;
  logic [31:0] kk_r;
  logic [72:0] prod_r;
  logic [15:0] nx_r, ny_r, nz_r;

  logic signed [ACC_W-1:0] cur;
  logic [ACC_W-1:0] acur;
  logic [15:0] mid;
  logic [16:0] k;
  logic [15:0] nsat;
  logic [15:0] nsig;

  always_comb begin
    case (comp_r)
      2'd0:    cur = vec_r.x;
      2'd1:    cur = vec_r.y;
      default: cur = vec_r.z;
    endcase
    acur = cur[ACC_W-1] ? ACC_W'(-cur) : ACC_W'(cur);
    // mid = ceil((lo+hi)/2), hi up to 32768 held as 16 bits plus overflow
    mid  = 16'((17'(lo_r) + 17'(hi_r) + 17'd1) >> 1);
    k    = {mid, 1'b0} - 17'd1;
    nsat = (lo_r > 16'd32767) ? 16'd32767 : lo_r;
    nsig = cur[ACC_W-1] ? 16'(-nsat) : nsat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done    <= 1'b0;
    end else begin
      done <= (state_r == S_KK) && (lo_r == hi_r) && (comp_r == 2'd2);
      unique case (state_r)
        S_IDLE: if (start) begin
          vec_r   <= vec;
          comp_r  <= 2'd0;
          sqi_r   <= 2'd0;
          sq_r    <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          // square of the current component into sqp, summed into sq in S_SUM
          sqp_r   <= SQ_W'(acur) * SQ_W'(acur);
          state_r <= S_SUM;
        end
        S_SUM: begin
          sq_r <= sq_r + sqp_r;
          if (sqi_r == 2'd2) begin
            comp_r  <= 2'd0;
            state_r <= S_FIN;
            lo_r    <= '0;
            hi_r    <= 16'd32768;
          end else begin
            sqi_r   <= sqi_r + 2'd1;
            comp_r  <= comp_r + 2'd1;
            state_r <= S_SQ;
          end
        end
        S_FIN: begin
          // start of a component: a^2
          ax2_r   <= SQ_W'(acur) * SQ_W'(acur);
          lo_r    <= '0;
          hi_r    <= 16'd32768;
          state_r <= S_KK;
        end
        S_KK: begin
          if (lo_r == hi_r) begin
            unique case (comp_r)
              2'd0:    nx_r <= nsig;
              2'd1:    ny_r <= nsig;
              default: nz_r <= nsig;
            endcase
            if (comp_r == 2'd2) begin
              state_r <= S_IDLE;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= S_FIN;
            end
          end else begin
            kk_r    <= 32'(k) * 32'(k);
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // k^2*S as two 32x20 partial products
          prod_r  <= 73'(kk_r) * 73'(sq_r[SQ_W/2-1:0]);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= prod_r + ((73'(kk_r) * 73'(sq_r[SQ_W-1:SQ_W/2])) << (SQ_W/2));
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (prod_r <= {1'b0, ax2_r, 32'd0}) lo_r <= mid;
          else hi_r <= mid - 16'd1;
          state_r <= S_KK;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign nx = nx_r;
  assign ny = ny_r;
  assign nz = nz_r;
endmodule
`default_nettype wire

### design/heightmap_vertex_normal_engine.sv
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_engine
// Height store plus vertex normal query over the adjacent triangles.
// ----------------------------------------------------------------------------
// Usage:
//  in_ word: op 0 writes height_byte at (row,col); op 1 queries vertex
//  (row,col). A write gives no result; writes can go back to back. A
//  query reads nine heights (3x3 around the vertex), one per cycle from
//  the single read port of the height RAM, sums the face normals in one
//  step, then normalizes: |v|^2 as three squares summed in turn, then per
//  component a 15- or 16-step search, each step through S_KK, S_MUL,
//  S_MUL2 and S_CMP (split multiply). A query with no triangle inside the
//  grid skips the normalizer and gives the up vector.
//  in_tready is high only while no query is in flight.
//  Result appears on out_ as one word and stays until out_tready; the next
//  word is accepted while a result waits, but a following query holds its
//  result (and in_tready low) until the output register is free.
//  Reset returns the grid registers to 256/256/10; the height RAM is not
//  cleared and must be written before it is read.
//  cfg_: write enable, index, 9-bit data; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module heightmap_vertex_normal_engine
  import hvn_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // row[7:0], col[15:8], height_byte[23:16]
  input  wire         in_tuser,   // op
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata,  // normal_x, normal_y, normal_z
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [8:0]  cfg_data
);
  localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RB + CB;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_NRM  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_BUSY = 3'd5;

  logic [8:0] rows_r, cols_r;
  logic [7:0] scale_r;
  logic [2:0] state_r;
  logic [7:0] qi_r, qj_r;
  logic [3:0] rd_r;
  logic [3:0] cap_r;
  logic       cap_v_r;
  logic [7:0] h_r [9];
  vec_t       acc_r;
  logic       nstart;
  logic       ndone;
  logic [15:0] nx, ny, nz;
  logic       ovalid_r;
  logic [47:0] odata_r;
  logic       in_acc;
  logic       oload;

  logic [7:0] wr_row, wr_col;
  logic       we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] rdata;

  logic signed [9:0]  rr, rc;
  logic [9:0]  rows_e, cols_e;

  logic signed [ACC_W-1:0] acc_nxt_x, acc_nxt_y, acc_nxt_z;

  assign wr_row = in_tdata[7:0];
  assign wr_col = in_tdata[15:8];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign we = in_acc && (in_tuser == OP_WRITE) &&
              (32'(wr_row) < MAX_ROWS) && (32'(wr_col) < MAX_COLS);
  assign waddr = {RB'(wr_row), CB'(wr_col)};

  // 3x3 window, rd index 0..8 -> (qi-1+rd/3, qj-1+rd%3)
  always_comb begin
    logic [1:0] dr, dc;
    dr = 2'd0;
    dc = 2'd0;
    case (rd_r)
      4'd0: begin dr = 2'd0; dc = 2'd0; end
      4'd1: begin dr = 2'd0; dc = 2'd1; end
      4'd2: begin dr = 2'd0; dc = 2'd2; end
      4'd3: begin dr = 2'd1; dc = 2'd0; end
      4'd4: begin dr = 2'd1; dc = 2'd1; end
      4'd5: begin dr = 2'd1; dc = 2'd2; end
      4'd6: begin dr = 2'd2; dc = 2'd0; end
      4'd7: begin dr = 2'd2; dc = 2'd1; end
      default: begin dr = 2'd2; dc = 2'd2; end
    endcase
    rr = $signed({2'b0, qi_r}) - 10'sd1 + $signed({8'd0, dr});
    rc = $signed({2'b0, qj_r}) - 10'sd1 + $signed({8'd0, dc});
    raddr = {RB'(rr[7:0]), CB'(rc[7:0])};
  end

  assign rows_e = (32'(rows_r) > MAX_ROWS) ? 10'(MAX_ROWS) : {1'b0, rows_r};
  assign cols_e = (32'(cols_r) > MAX_COLS) ? 10'(MAX_COLS) : {1'b0, cols_r};

  hvn_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_tdata[23:16]),
    .raddr(raddr), .rdata(rdata)
  );

  // cell (qi-1+a, qj-1+b) inside grid
  function automatic logic cell_in(input logic [7:0] i, input logic [7:0] j,
                                   input logic a, input logic b,
                                   input logic [9:0] nr, input logic [9:0] nc);
    logic [9:0] r, c;
    r = {2'b0, i} + {9'd0, a};
    c = {2'b0, j} + {9'd0, b};
    return (r >= 10'd1) && (c >= 10'd1) && (r < nr) && (c < nc);
  endfunction

  // signed height difference at accumulator width
  function automatic logic signed [ACC_W-1:0] hdiff(input logic [7:0] p,
                                                    input logic [7:0] q);
    return $signed(ACC_W'(p)) - $signed(ACC_W'(q));
  endfunction

  // accumulate all four cells in one step from the captured window
  always_comb begin
    logic signed [ACC_W-1:0] ux [4];
    logic signed [ACC_W-1:0] uz [4];
    logic signed [ACC_W-1:0] lx [4];
    logic signed [ACC_W-1:0] lz [4];
    logic signed [ACC_W-1:0] s;
    logic [3:0] vin;
    s = $signed(ACC_W'(scale_r));
    for (int q = 0; q < 4; q++) begin
      int a, b;
      a = q / 2;
      b = q % 2;
      ux[q] = s * hdiff(h_r[a*3+b+1], h_r[a*3+b+4]);
      uz[q] = s * hdiff(h_r[a*3+b], h_r[a*3+b+1]);
      lx[q] = s * hdiff(h_r[a*3+b], h_r[a*3+b+3]);
      lz[q] = s * hdiff(h_r[a*3+b+3], h_r[a*3+b+4]);
    end
    vin[0] = cell_in(qi_r, qj_r, 1'b0, 1'b0, rows_e, cols_e);
    vin[1] = cell_in(qi_r, qj_r, 1'b0, 1'b1, rows_e, cols_e);
    vin[2] = cell_in(qi_r, qj_r, 1'b1, 1'b0, rows_e, cols_e);
    vin[3] = cell_in(qi_r, qj_r, 1'b1, 1'b1, rows_e, cols_e);
    // cell0 both, cell3 both, cell1 (i-1,j) lower, cell2 (i,j-1) upper
    acc_nxt_x = '0; acc_nxt_y = '0; acc_nxt_z = '0;
    if (vin[0]) begin
      acc_nxt_x = acc_nxt_x + ux[0] + lx[0];
      acc_nxt_y = acc_nxt_y + ACC_W'(510);
      acc_nxt_z = acc_nxt_z + uz[0] + lz[0];
    end
    if (vin[3]) begin
      acc_nxt_x = acc_nxt_x + ux[3] + lx[3];
      acc_nxt_y = acc_nxt_y + ACC_W'(510);
      acc_nxt_z = acc_nxt_z + uz[3] + lz[3];
    end
    if (vin[1]) begin
      acc_nxt_x = acc_nxt_x + lx[1];
      acc_nxt_y = acc_nxt_y + ACC_W'(255);
      acc_nxt_z = acc_nxt_z + lz[1];
    end
    if (vin[2]) begin
      acc_nxt_x = acc_nxt_x + ux[2];
      acc_nxt_y = acc_nxt_y + ACC_W'(255);
      acc_nxt_z = acc_nxt_z + uz[2];
    end
  end

  assign nstart = (state_r == S_NRM);
  // result goes to the output register once it is free
  assign oload  = (state_r == S_WAIT) && (!ovalid_r || out_tready);

  hvn_norm u_norm (
    .clk(clk), .rst_n(rst_n), .start(nstart), .vec(acc_r),
    .done(ndone), .nx(nx), .ny(ny), .nz(nz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= 9'd256;
      cols_r   <= 9'd256;
      scale_r  <= 8'd10;
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      cap_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS:  rows_r  <= cfg_data;
          CFG_COLS:  cols_r  <= cfg_data;
          CFG_SCALE: scale_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (oload) ovalid_r <= 1'b1;
      else if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      cap_v_r <= (state_r == S_RD);
      if (cap_v_r) h_r[cap_r] <= rdata;
      unique case (state_r)
        S_IDLE: if (in_acc && in_tuser == OP_QUERY) begin
          qi_r    <= wr_row;
          qj_r    <= wr_col;
          rd_r    <= 4'd0;
          state_r <= S_RD;
        end
        S_RD: begin
          cap_r   <= rd_r;
          if (rd_r == 4'd8) state_r <= S_ACC;
          else rd_r <= rd_r + 4'd1;
        end
        S_ACC: if (!cap_v_r) begin
          acc_r.x <= acc_nxt_x;
          acc_r.y <= acc_nxt_y;
          acc_r.z <= acc_nxt_z;
          if (acc_nxt_y == '0) begin
            state_r <= S_WAIT;
          end else begin
            state_r <= S_NRM;
          end
        end
        S_NRM: state_r <= S_BUSY;
        S_BUSY: if (ndone) state_r <= S_WAIT;
        S_WAIT: if (oload) begin
          odata_r <= (acc_r.y == '0) ? {16'd0, 16'd32767, 16'd0} : {nz, ny, nx};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule
`default_nettype wire

### bench/heightmap_vertex_normal_engine_test.sv
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_engine_test
// Writes heights around chosen vertices, queries their normals and checks
// each result word against a bit-exact predictor of the face-average normal,
// across several grid and scale settings and with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module heightmap_vertex_normal_engine_test
  import hvn_pkg::*;
();

  localparam logic [1:0] CFG_SPARE = 2'd3;   // no register here
  localparam int STORE_DIM = 256;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;

  class vertex_normal_predictor;
    bit [7:0] heights [STORE_DIM*STORE_DIM];
    int unsigned rows_cfg, cols_cfg, scale_cfg;
    longint sum_x, sum_y, sum_z;
    logic [47:0] pending_normals [$];
    int errors;

    function new();
      rows_cfg = 256;
      cols_cfg = 256;
      scale_cfg = 10;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, int unsigned val);
      case (idx)
        CFG_ROWS:  rows_cfg = val & 9'h1ff;
        CFG_COLS:  cols_cfg = val & 9'h1ff;
        CFG_SCALE: scale_cfg = val & 8'hff;
        default: ;
      endcase
    endfunction

    function longint hgt(int r, int c);
      return longint'(heights[r*STORE_DIM + c]);
    endfunction

    // which: bit0 upper triangle, bit1 lower triangle
    function void add_cell(int r, int c, int which);
      int nr, nc;
      longint s, b00, b01, b10, b11;
      nr = rows_cfg > STORE_DIM ? STORE_DIM : rows_cfg;
      nc = cols_cfg > STORE_DIM ? STORE_DIM : cols_cfg;
      if (r < 0 || c < 0 || r + 1 >= nr || c + 1 >= nc) return;
      s = scale_cfg;
      b00 = hgt(r, c);
      b01 = hgt(r, c + 1);
      b10 = hgt(r + 1, c);
      b11 = hgt(r + 1, c + 1);
      if (which & 1) begin
        sum_x += s * (b01 - b11);
        sum_y += 255;
        sum_z += s * (b00 - b01);
      end
      if (which & 2) begin
        sum_x += s * (b00 - b10);
        sum_y += 255;
        sum_z += s * (b10 - b11);
      end
    endfunction

    // largest n in [0,32768] with (2n-1)^2 * S <= v^2 * 2^32, clipped, signed
    function logic [15:0] to_q15(longint v, longint sq);
      logic [127:0] lhs, rhs, k;
      int lo, hi, mid;
      longint a;
      a = v < 0 ? -v : v;
      lhs = (128'(a) * 128'(a)) << 32;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        k = 128'(2 * mid - 1);
        rhs = k * k * 128'(sq);
        if (rhs <= lhs) lo = mid;
        else hi = mid - 1;
      end
      if (lo > 32767) lo = 32767;
      return v < 0 ? 16'(-lo) : 16'(lo);
    endfunction

    function void note_word(logic op, int r, int c, logic [7:0] h);
      longint sq;
      if (op == OP_WRITE) begin
        heights[r*STORE_DIM + c] = h;
        return;
      end
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      add_cell(r - 1, c - 1, 3);
      add_cell(r, c, 3);
      add_cell(r - 1, c, 2);
      add_cell(r, c - 1, 1);
      if (sum_y == 0) begin
        pending_normals.push_back({16'd0, 16'd32767, 16'd0});
        return;
      end
      sq = sum_x*sum_x + sum_y*sum_y + sum_z*sum_z;
      pending_normals.push_back({to_q15(sum_z, sq), to_q15(sum_y, sq), to_q15(sum_x, sq)});
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
      errors++;
    endtask

    task check_normal(logic [47:0] word);
      logic [47:0] want;
      if (pending_normals.size() == 0) begin
        $display("unexpected result word %h", word);
        errors++;
        return;
      end
      want = pending_normals.pop_front();
      if (word[15:0] !== want[15:0]) report("normal_x", word[15:0], want[15:0]);
      if (word[31:16] !== want[31:16]) report("normal_y", word[31:16], want[31:16]);
      if (word[47:32] !== want[47:32]) report("normal_z", word[47:32], want[47:32]);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;   // row[7:0], col[15:8], height_byte[23:16]
  logic in_tuser = 1'b0;        // op
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;       // normal_x[15:0], normal_y[31:16], normal_z[47:32]
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  vertex_normal_predictor normals = new();
  bit written [STORE_DIM*STORE_DIM];
  int send_idle = 0;
  int recv_idle = 0;
  int words_sent = 0;
  int cycles = 0;

  heightmap_vertex_normal_engine dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[heightmap_vertex_normal_engine] ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) normals.check_normal(out_tdata);

  always @(negedge clk)
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle);

  task send_word(logic op, int r, int c, logic [7:0] h);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {h, 8'(c), 8'(r)};
    do @(posedge clk); while (!in_tready);
    normals.note_word(op, r, c, h);
    if (op == OP_WRITE) written[r*STORE_DIM + c] = 1'b1;
    words_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task write_reg(logic [1:0] idx, int unsigned val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = 9'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    normals.set_reg(idx, val);
  endtask

  function logic [7:0] pick_height();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // fill every unwritten height in the 3x3 patch, maybe touch one again, query
  task patch_query(int r, int c);
    int rr, cc;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++) begin
        rr = r + dr;
        cc = c + dc;
        if (rr >= 0 && rr < STORE_DIM && cc >= 0 && cc < STORE_DIM && !written[rr*STORE_DIM+cc])
          send_word(OP_WRITE, rr, cc, pick_height());
      end
    if ($urandom_range(9) < 3) begin
      rr = r + int'($urandom_range(2)) - 1;
      cc = c + int'($urandom_range(2)) - 1;
      if (rr >= 0 && rr < STORE_DIM && cc >= 0 && cc < STORE_DIM)
        send_word(OP_WRITE, rr, cc, pick_height());
    end
    send_word(OP_QUERY, r, c, 8'($urandom));
  endtask

  task random_phase(int quota);
    int stop, span, r, c;
    stop = words_sent + quota;
    span = normals.rows_cfg > normals.cols_cfg ? normals.rows_cfg : normals.cols_cfg;
    while (words_sent < stop) begin
      if ($urandom_range(9) == 0) begin
        // stray write anywhere
        send_word(OP_WRITE, $urandom_range(255), $urandom_range(255), pick_height());
      end else if ($urandom_range(9) < 6 && span <= STORE_DIM) begin
        r = $urandom_range(normals.rows_cfg);
        c = $urandom_range(normals.cols_cfg);
        patch_query(r > 255 ? 255 : r, c > 255 ? 255 : c);
      end else begin
        patch_query($urandom_range(255), $urandom_range(255));
      end
    end
  endtask

  task settle();
    while (normals.pending_normals.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle = 20;
    recv_idle = 87;
    // directed: steepest slopes at both store corners, default registers
    send_word(OP_WRITE, 0, 0, 8'd255);
    send_word(OP_WRITE, 0, 1, 8'd0);
    send_word(OP_WRITE, 1, 0, 8'd0);
    send_word(OP_WRITE, 1, 1, 8'd255);
    send_word(OP_QUERY, 0, 0, 8'd0);
    send_word(OP_WRITE, 255, 255, 8'd0);
    send_word(OP_WRITE, 254, 254, 8'd255);
    send_word(OP_WRITE, 254, 255, 8'd255);
    send_word(OP_WRITE, 255, 254, 8'd0);
    send_word(OP_QUERY, 255, 255, 8'd255);
    patch_query(128, 127);
    random_phase(110);
    settle();

    // smallest grid with a triangle, smallest nonzero scale, spare index ignored
    write_reg(CFG_ROWS, 2);
    write_reg(CFG_COLS, 2);
    write_reg(CFG_SCALE, 1);
    write_reg(CFG_SPARE, 9'h1ff);
    patch_query(0, 0);
    patch_query(1, 1);
    patch_query(2, 2);
    random_phase(100);
    settle();

    send_idle = 87;
    recv_idle = 20;
    // grid beyond the store, largest scale
    write_reg(CFG_ROWS, 511);
    write_reg(CFG_COLS, 300);
    write_reg(CFG_SCALE, 255);
    random_phase(120);
    settle();

    // degenerate grid: every query gives the up vector
    write_reg(CFG_ROWS, 0);
    write_reg(CFG_COLS, 1);
    write_reg(CFG_SCALE, 0);
    random_phase(80);
    settle();

    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_ROWS, $urandom_range(256, 2));
    write_reg(CFG_COLS, $urandom_range(256, 2));
    write_reg(CFG_SCALE, $urandom_range(255, 1));
    random_phase(150);
    settle();

    write_reg(CFG_ROWS, $urandom_range(20, 2));
    write_reg(CFG_COLS, 256);
    write_reg(CFG_SCALE, $urandom_range(255, 1));
    random_phase(120);
    settle();

    if (normals.errors == 0 && normals.pending_normals.size() == 0) begin
      $display("[heightmap_vertex_normal_engine] OK");
    end else begin
      $display("[heightmap_vertex_normal_engine] ERROR");
    end
    $finish;
  end
endmodule
